[rtl/elgamal_modular_cipher_unit_assert.svh]
// Assertion macros for the ElGamal cipher unit.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef ELGAMAL_MODULAR_CIPHER_UNIT_ASSERT_SVH
`define ELGAMAL_MODULAR_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define EMC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/emc_pkg.sv]
// Shared types and codes for the ElGamal cipher unit.
// No dependencies.
package emc_pkg;

    localparam int FIELD_W = 31;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_KEYGEN  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_GENERATOR   = 2'd1;
    localparam logic [1:0] REG_PRIVATE_KEY = 2'd2;
    localparam logic [1:0] REG_PUBLIC_KEY  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POW_RED,
        ST_POW_SQ,
        ST_POW_MUL,
        ST_POW_NEXT,
        ST_POW_END,
        ST_INV_TEST,
        ST_INV_STEP,
        ST_INV_FIX,
        ST_FIN_RED,
        ST_FIN_MUL,
        ST_DONE
    } state_t;

endpackage

[rtl/emc_modmul.sv]
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the top level.
module emc_modmul #(
    parameter int W = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W:0]   b,
    input  logic [W-1:0] q,
    output logic         done,
    output logic [W-1:0] p
);

    localparam int CW = $clog2(W + 2);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  a_reg, q_reg, acc_reg, acc_next;
    logic [W:0]    b_reg;
    logic [W+1:0]  sum, q1, q2;

    // The addend is below q, so one step stays under 3q.
    always_comb
    begin
        q1       = {2'b00, q_reg};
        q2       = {1'b0, q_reg, 1'b0};
        sum      = {1'b0, acc_reg, 1'b0} + (b_reg[W] ? {2'b00, a_reg} : '0);
        acc_next = (sum >= q2) ? W'(sum - q2) : ((sum >= q1) ? W'(sum - q1) : W'(sum));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W + 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a;
            b_reg   <= b;
            q_reg   <= q;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-1:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

[rtl/emc_divstep.sv]
// One extended-Euclid step: bit-serial restoring division of num by den,
// accumulating quo*prev alongside, then new coefficient cur - quo*prev.
module emc_divstep #(
    parameter int W = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [W-1:0]        num,
    input  logic [W-1:0]        den,
    input  logic signed [W+2:0] prev,
    input  logic signed [W+2:0] cur,
    output logic                done,
    output logic [W-1:0]        rem,
    output logic signed [W+2:0] nprev
);

    localparam int CW = $clog2(W + 1);

    logic                busy_reg, done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [W-1:0]        num_reg, den_reg, r_reg, r_next;
    logic signed [W+2:0] prev_reg, cur_reg, t_reg, t_next;
    logic [W:0]          rs;
    logic                ge;

    always_comb
    begin
        rs     = {r_reg, num_reg[W-1]};
        ge     = (rs >= {1'b0, den_reg});
        r_next = ge ? W'(rs - {1'b0, den_reg}) : W'(rs);
        t_next = (t_reg <<< 1) + (ge ? prev_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            num_reg  <= num;
            den_reg  <= den;
            prev_reg <= prev;
            cur_reg  <= cur;
            r_reg    <= '0;
            t_reg    <= '0;
        end
        else if (busy_reg)
        begin
            r_reg   <= r_next;
            t_reg   <= t_next;
            num_reg <= {num_reg[W-2:0], 1'b0};
        end
    end

    assign done  = done_reg;
    assign rem   = r_reg;
    assign nprev = cur_reg - t_reg;

endmodule

[rtl/elgamal_modular_cipher_unit.sv]
// Top level of the ElGamal cipher unit: sequencer, operand registers, output register.
// Depends on emc_pkg, emc_modmul, emc_divstep and the assertion header.
//
// Usage: configuration registers (modulus, generator, private key, public key) are
// written through wr_en/wr_index/wr_data while the unit is idle. Items enter on the
// s_ channel: s_tuser carries the opcode (0 keygen, 1 encrypt, 2 decrypt), s_tdata
// the message, ephemeral exponent, C1 and C2. Opcode 3 is dropped with no result.
// Each result leaves on the m_ channel: m_tuser echoes the opcode, m_tdata holds the
// primary value and the secondary value (C2 for encrypt, zero otherwise).
// One item is worked on at a time. All multiplications go through one bit-serial
// modular multiplier; a power costs one reduction plus up to 2*MOD_BITS
// multiplications. Keygen needs one power, encrypt two powers and a multiply,
// decrypt one power, an extended-Euclid inverse whose steps each pass the loop
// test and a bit-serial division, and two multiplies. A modulus below two gives
// zero values.
// The result sits in an output register; a new item is accepted while it waits, and
// a stalled receiver only holds the sequencer at its final step. Reset clears the
// registers to modulus 2 and all else zero, and empties the output register.
`include "elgamal_modular_cipher_unit_assert.svh"

module elgamal_modular_cipher_unit #(
    parameter int MOD_BITS = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [1:0]   wr_index,
    input  logic [30:0]  wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low bit up: message[30:0], ephemeral[61:31], cipher_first[92:62],
    // cipher_second[123:93], zero pad[127:124]
    input  logic [127:0] s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low bit up: primary_value[30:0], secondary_value[61:31], zero pad[63:62]
    output logic [63:0]  m_tdata,
    // m_tuser: done_kind[1:0]
    output logic [1:0]   m_tuser
);

    localparam int W  = MOD_BITS;
    localparam int SW = MOD_BITS + 3;
    localparam int CW = $clog2(MOD_BITS + 1);

    emc_pkg::state_t state_reg, state_next;

    // Configuration registers, kept at MOD_BITS bits.
    logic [W-1:0] modulus_reg, generator_reg, private_key_reg, public_key_reg;

    logic [1:0]    op_reg;
    logic          pass_reg;
    logic [W-1:0]  msg_reg, eph_reg, c2_reg;
    logic [W-1:0]  base_reg, baser_reg, exp_reg, acc_reg, shared_reg, fa_reg;
    logic [W:0]    fb_reg;
    logic [CW-1:0] bit_cnt_reg;
    logic [W-1:0]  prim_reg, sec_reg;

    logic [W-1:0]         num_reg, den_reg;
    logic signed [SW-1:0] prev_reg, cur_reg, fix_sum;

    logic         out_valid_reg;
    logic [1:0]   out_kind_reg;
    logic [30:0]  out_prim_reg, out_sec_reg;

    logic         mul_issued_reg, div_issued_reg;
    logic         mul_start, mul_done, div_start, div_done;
    logic [W-1:0] mul_a, mul_p, div_rem;
    logic [W:0]   mul_b;
    logic signed [SW-1:0] div_nprev;

    logic         in_accept, out_free, q_small;
    logic [1:0]   in_op;

    assign in_op     = s_tuser;
    assign s_tready  = (state_reg == emc_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign q_small   = (modulus_reg < W'(2));

    // The inverse coefficient folded into [0, q).
    assign fix_sum = cur_reg + (cur_reg[SW-1] ? SW'(modulus_reg) : SW'(0));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            emc_pkg::ST_IDLE:
            begin
                if (in_accept && in_op != emc_pkg::OP_UNUSED)
                    state_next = q_small ? emc_pkg::ST_DONE : emc_pkg::ST_POW_RED;
            end
            emc_pkg::ST_POW_RED:
            begin
                if (mul_done)
                    state_next = emc_pkg::ST_POW_SQ;
            end
            emc_pkg::ST_POW_SQ:
            begin
                if (mul_done)
                    state_next = exp_reg[W-1] ? emc_pkg::ST_POW_MUL : emc_pkg::ST_POW_NEXT;
            end
            emc_pkg::ST_POW_MUL:
            begin
                if (mul_done)
                    state_next = emc_pkg::ST_POW_NEXT;
            end
            emc_pkg::ST_POW_NEXT:
            begin
                state_next = (bit_cnt_reg == CW'(1)) ? emc_pkg::ST_POW_END : emc_pkg::ST_POW_SQ;
            end
            emc_pkg::ST_POW_END:
            begin
                unique case (op_reg)
                    emc_pkg::OP_KEYGEN:  state_next = emc_pkg::ST_DONE;
                    emc_pkg::OP_ENCRYPT:
                        state_next = pass_reg ? emc_pkg::ST_FIN_MUL : emc_pkg::ST_POW_RED;
                    default:             state_next = emc_pkg::ST_INV_TEST;
                endcase
            end
            emc_pkg::ST_INV_TEST:
            begin
                state_next = (num_reg > W'(1) && den_reg != '0) ? emc_pkg::ST_INV_STEP
                                                              : emc_pkg::ST_INV_FIX;
            end
            emc_pkg::ST_INV_STEP:
            begin
                if (div_done)
                    state_next = emc_pkg::ST_INV_TEST;
            end
            emc_pkg::ST_INV_FIX:  state_next = emc_pkg::ST_FIN_RED;
            emc_pkg::ST_FIN_RED:
            begin
                if (mul_done)
                    state_next = emc_pkg::ST_FIN_MUL;
            end
            emc_pkg::ST_FIN_MUL:
            begin
                if (mul_done)
                    state_next = emc_pkg::ST_DONE;
            end
            emc_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = emc_pkg::ST_IDLE;
            end
            default: state_next = emc_pkg::ST_IDLE;
        endcase
    end

    // Unit starts and operand selection.
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = W'(1);
        mul_b     = {1'b0, base_reg};
        unique case (state_reg)
            emc_pkg::ST_POW_RED:
            begin
                mul_start = !mul_issued_reg;
            end
            emc_pkg::ST_POW_SQ:
            begin
                mul_start = !mul_issued_reg;
                mul_a     = acc_reg;
                mul_b     = {1'b0, acc_reg};
            end
            emc_pkg::ST_POW_MUL:
            begin
                mul_start = !mul_issued_reg;
                mul_a     = acc_reg;
                mul_b     = {1'b0, baser_reg};
            end
            emc_pkg::ST_FIN_RED:
            begin
                mul_start = !mul_issued_reg;
                mul_b     = fb_reg;
            end
            emc_pkg::ST_FIN_MUL:
            begin
                mul_start = !mul_issued_reg;
                mul_a     = fa_reg;
                mul_b     = fb_reg;
            end
            emc_pkg::ST_INV_STEP:
            begin
                div_start = !div_issued_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    emc_modmul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .q     (modulus_reg),
        .done  (mul_done),
        .p     (mul_p)
    );

    emc_divstep #(.W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .prev  (prev_reg),
        .cur   (cur_reg),
        .done  (div_done),
        .rem   (div_rem),
        .nprev (div_nprev)
    );

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= emc_pkg::ST_IDLE;
            modulus_reg     <= W'(2);
            generator_reg   <= '0;
            private_key_reg <= '0;
            public_key_reg  <= '0;
            out_valid_reg   <= 1'b0;
            mul_issued_reg  <= 1'b0;
            div_issued_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    emc_pkg::REG_MODULUS:     modulus_reg     <= wr_data[W-1:0];
                    emc_pkg::REG_GENERATOR:   generator_reg   <= wr_data[W-1:0];
                    emc_pkg::REG_PRIVATE_KEY: private_key_reg <= wr_data[W-1:0];
                    emc_pkg::REG_PUBLIC_KEY:  public_key_reg  <= wr_data[W-1:0];
                    default:                  modulus_reg     <= modulus_reg;
                endcase
            end
            if (mul_start)
                mul_issued_reg <= 1'b1;
            else if (mul_done)
                mul_issued_reg <= 1'b0;
            if (div_start)
                div_issued_reg <= 1'b1;
            else if (div_done)
                div_issued_reg <= 1'b0;
            if (state_reg == emc_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            emc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_reg      <= in_op;
                    pass_reg    <= 1'b0;
                    msg_reg     <= s_tdata[W-1:0];
                    eph_reg     <= s_tdata[31 +: W];
                    c2_reg      <= s_tdata[93 +: W];
                    prim_reg    <= '0;
                    sec_reg     <= '0;
                    bit_cnt_reg <= CW'(W);
                    unique case (in_op)
                        emc_pkg::OP_KEYGEN:
                        begin
                            base_reg <= generator_reg;
                            exp_reg  <= private_key_reg;
                        end
                        emc_pkg::OP_ENCRYPT:
                        begin
                            base_reg <= public_key_reg;
                            exp_reg  <= s_tdata[31 +: W];
                        end
                        default:
                        begin
                            base_reg <= s_tdata[62 +: W];
                            exp_reg  <= private_key_reg;
                        end
                    endcase
                end
            end
            emc_pkg::ST_POW_RED:
            begin
                if (mul_done)
                begin
                    baser_reg <= mul_p;
                    acc_reg   <= W'(1);
                end
            end
            emc_pkg::ST_POW_SQ, emc_pkg::ST_POW_MUL:
            begin
                if (mul_done)
                    acc_reg <= mul_p;
            end
            emc_pkg::ST_POW_NEXT:
            begin
                exp_reg     <= {exp_reg[W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
            emc_pkg::ST_POW_END:
            begin
                case (op_reg)
                    emc_pkg::OP_KEYGEN:
                    begin
                        prim_reg <= acc_reg;
                    end
                    emc_pkg::OP_ENCRYPT:
                    begin
                        if (pass_reg)
                        begin
                            prim_reg <= acc_reg;
                            fa_reg   <= shared_reg;
                            fb_reg   <= {1'b0, msg_reg};
                        end
                        else
                        begin
                            shared_reg  <= acc_reg;
                            pass_reg    <= 1'b1;
                            base_reg    <= generator_reg;
                            exp_reg     <= eph_reg;
                            bit_cnt_reg <= CW'(W);
                        end
                    end
                    default:
                    begin
                        num_reg  <= acc_reg;
                        den_reg  <= modulus_reg;
                        prev_reg <= '0;
                        cur_reg  <= SW'(1);
                    end
                endcase
            end
            emc_pkg::ST_INV_STEP:
            begin
                if (div_done)
                begin
                    num_reg  <= den_reg;
                    den_reg  <= div_rem;
                    prev_reg <= div_nprev;
                    cur_reg  <= prev_reg;
                end
            end
            emc_pkg::ST_INV_FIX:
            begin
                fb_reg <= fix_sum[SW-1] ? '0 : fix_sum[W:0];
            end
            emc_pkg::ST_FIN_RED:
            begin
                if (mul_done)
                begin
                    fa_reg <= mul_p;
                    fb_reg <= {1'b0, c2_reg};
                end
            end
            emc_pkg::ST_FIN_MUL:
            begin
                if (mul_done)
                begin
                    if (op_reg == emc_pkg::OP_ENCRYPT)
                        sec_reg <= mul_p;
                    else
                        prim_reg <= mul_p;
                end
            end
            emc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_kind_reg <= op_reg;
                    out_prim_reg <= 31'(prim_reg);
                    out_sec_reg  <= 31'(sec_reg);
                end
            end
            default:
            begin
                pass_reg <= pass_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_sec_reg, out_prim_reg};

    `EMC_ASSERT_NEXT(a_done_loads, state_reg == emc_pkg::ST_DONE && out_free, out_valid_reg,
        "result not loaded into output register")
    `EMC_ASSERT_IMPL(a_mul_issued, mul_done, mul_issued_reg,
        "multiplier finished without a start")
    `EMC_ASSERT_IMPL(a_div_state, div_done, state_reg == emc_pkg::ST_INV_STEP,
        "divider finished outside the inverse step")

endmodule

[tb/tb.sv]
// Self-checking testbench for the ElGamal cipher unit: keygen, encrypt and decrypt items
// are predicted in the testbench and checked against every result. Depends on emc_pkg and elgamal_modular_cipher_unit.
`timescale 1ns / 100ps

module tb;

    localparam int          W           = emc_pkg::FIELD_W;
    localparam longint      CYCLE_LIMIT = 8_000_000;
    localparam int          SETTLE      = 100;

    typedef struct packed {
        logic [emc_pkg::OP_W-1:0] kind;
        logic [W-1:0]             prim;
        logic [W-1:0]             sec;
    } cipher_result_t;

    // Idle styles of the two sides.
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_style_t;

    logic         clk;
    logic         rst_n;
    logic         wr_en;
    logic [1:0]   wr_index;
    logic [30:0]  wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    // Shadow copy of the four registers, used by the predictor.
    logic [W-1:0] q_mod;
    logic [W-1:0] gen_base;
    logic [W-1:0] priv_exp;
    logic [W-1:0] pub_val;

    cipher_result_t pending_results[$];
    idle_style_t    idle_style;
    int             hold_left;
    int             errors;
    longint         cycles;

    elgamal_modular_cipher_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Left-to-right square-and-multiply over every exponent bit, starting from one.
    function automatic longint unsigned power_mod(longint unsigned b, logic [W-1:0] e,
                                                  longint unsigned q);
        longint unsigned acc;
        acc = 1;
        for (int i = W - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % q;
            if (e[i])
                acc = (acc * b) % q;
        end
        return acc;
    endfunction

    // Extended Euclid; the loop stops early on a zero remainder, so a zero value
    // gives an inverse of one and a composite modulus keeps the current coefficient.
    function automatic longint unsigned inverse_mod(longint unsigned v, longint unsigned q);
        longint num;
        longint den;
        longint prev;
        longint cur;
        longint quo;
        longint rem;
        longint tmp;
        num  = v;
        den  = q;
        prev = 0;
        cur  = 1;
        while (num > 1 && den != 0)
        begin
            quo  = num / den;
            rem  = num % den;
            tmp  = prev;
            num  = den;
            den  = rem;
            prev = cur - quo * prev;
            cur  = tmp;
        end
        if (cur < 0)
            cur += longint'(q);
        if (cur < 0)
            cur = 0;
        return unsigned'(cur);
    endfunction

    function automatic cipher_result_t predict_cipher(logic [emc_pkg::OP_W-1:0] op,
                                                      logic [W-1:0] msg,
                                                      logic [W-1:0] eph, logic [W-1:0] c1,
                                                      logic [W-1:0] c2);
        cipher_result_t  r;
        longint unsigned q;
        longint unsigned shared;
        q      = q_mod;
        r.kind = op;
        r.prim = '0;
        r.sec  = '0;
        if (q >= 2)
        begin
            if (op == emc_pkg::OP_KEYGEN)
                r.prim = W'(power_mod(gen_base, priv_exp, q));
            else if (op == emc_pkg::OP_ENCRYPT)
            begin
                shared = power_mod(pub_val, eph, q);
                r.prim = W'(power_mod(gen_base, eph, q));
                r.sec  = W'((shared * msg) % q);
            end
            else
            begin
                shared = power_mod(c1, priv_exp, q);
                r.prim = W'((64'(c2) * inverse_mod(shared, q)) % q);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    // Registers are written only while nothing is in flight.
    task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en    <= 1'b0;
        case (idx)
            emc_pkg::REG_MODULUS:     q_mod    = val;
            emc_pkg::REG_GENERATOR:   gen_base = val;
            emc_pkg::REG_PRIVATE_KEY: priv_exp = val;
            default:                  pub_val  = val;
        endcase
    endtask

    task automatic write_all(logic [W-1:0] q, logic [W-1:0] g, logic [W-1:0] x,
                             logic [W-1:0] y);
        write_reg(emc_pkg::REG_MODULUS, q);
        write_reg(emc_pkg::REG_GENERATOR, g);
        write_reg(emc_pkg::REG_PRIVATE_KEY, x);
        write_reg(emc_pkg::REG_PUBLIC_KEY, y);
    endtask

    // Sends one item and records its expected result at the accepting edge. The valid
    // line is left high so that a following item can go out back to back.
    task automatic send_item(logic [emc_pkg::OP_W-1:0] op, logic [W-1:0] msg,
                             logic [W-1:0] eph, logic [W-1:0] c1, logic [W-1:0] c2);
        if ((idle_style == IDLE_SENDER && $urandom_range(0, 99) < 83) ||
            (idle_style == IDLE_BOTH && $urandom_range(0, 99) < 33))
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < (idle_style == IDLE_SENDER ? 83 : 33));
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, c2, c1, eph, msg};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op != emc_pkg::OP_UNUSED)
            pending_results.push_back(predict_cipher(op, msg, eph, c1, c2));
    endtask

    // Waits until every expected result is in; a dropped opcode leaves no work behind,
    // so a short settle is enough before registers change.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [W-1:0] rand_field();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return W'($urandom_range(0, 15));
            default: return W'($urandom);
        endcase
    endfunction

    function automatic logic [W-1:0] pick_modulus();
        case ($urandom_range(0, 9))
            0:       return 31'd2147483647;
            1:       return 31'd65521;
            2:       return 31'd7919;
            3:       return 31'd1000003;
            4:       return 31'd101;
            5:       return 31'd3;
            6:       return 31'd1000;
            7:       return 31'($urandom_range(0, 1));
            default: return W'($urandom);
        endcase
    endfunction

    // One random step: mostly keygen and encrypt-then-decrypt pairs that round-trip
    // through the real ciphertext, plus random decrypts, stray encrypts and opcode 3.
    task automatic send_random(ref int count);
        cipher_result_t enc;
        logic [W-1:0]   msg;
        logic [W-1:0]   eph;
        int             pick;
        pick = $urandom_range(0, 99);
        msg  = ($urandom_range(0, 3) == 0) ? rand_field() : W'($urandom % (q_mod | 31'd1));
        eph  = rand_field();
        if (pick < 25)
        begin
            send_item(emc_pkg::OP_KEYGEN, rand_field(), rand_field(), rand_field(),
                      rand_field());
            count++;
        end
        else if (pick < 65)
        begin
            enc = predict_cipher(emc_pkg::OP_ENCRYPT, msg, eph, '0, '0);
            send_item(emc_pkg::OP_ENCRYPT, msg, eph, rand_field(), rand_field());
            send_item(emc_pkg::OP_DECRYPT, rand_field(), rand_field(), enc.prim, enc.sec);
            count += 2;
        end
        else if (pick < 85)
        begin
            send_item(emc_pkg::OP_DECRYPT, rand_field(), rand_field(), rand_field(),
                      rand_field());
            count++;
        end
        else if (pick < 95)
        begin
            send_item(emc_pkg::OP_ENCRYPT, rand_field(), rand_field(), rand_field(),
                      rand_field());
            count++;
        end
        else
            send_item(emc_pkg::OP_UNUSED, rand_field(), rand_field(), rand_field(),
                      rand_field());
    endtask

    task automatic random_phase(idle_style_t style, int n_items);
        int count;
        count = 0;
        write_all(pick_modulus(), rand_field(), rand_field(), rand_field());
        idle_style = style;
        while (count < n_items)
        begin
            send_random(count);
            if (count % 12 == 11)
            begin
                drain();
                write_all(pick_modulus(), rand_field(), rand_field(), rand_field());
            end
        end
        drain();
    endtask

    task automatic test_directed;
        idle_style = IDLE_NONE;
        // Reset values: modulus two, everything else zero.
        send_item(emc_pkg::OP_KEYGEN, '0, '0, '0, '0);
        send_item(emc_pkg::OP_ENCRYPT, '1, '1, '0, '0);
        drain();
        // Small moduli give zero values.
        write_reg(emc_pkg::REG_MODULUS, 31'd0);
        send_item(emc_pkg::OP_KEYGEN, '1, '1, '1, '1);
        send_item(emc_pkg::OP_DECRYPT, '1, '1, '1, '1);
        drain();
        write_reg(emc_pkg::REG_MODULUS, 31'd1);
        send_item(emc_pkg::OP_ENCRYPT, '1, '1, '1, '1);
        send_item(emc_pkg::OP_UNUSED, '1, '1, '1, '1);
        drain();
        // Largest modulus and full-width operands, exponent zero among them.
        write_all('1, 31'd7, '1, 31'd2147483646);
        send_item(emc_pkg::OP_KEYGEN, '0, '0, '0, '0);
        send_item(emc_pkg::OP_ENCRYPT, 31'd2147483646, '1, '0, '0);
        send_item(emc_pkg::OP_ENCRYPT, 31'd12345, '0, '0, '0);
        send_item(emc_pkg::OP_DECRYPT, '0, '0, 31'd5, 31'd2147483646);
        // Shared value of zero: its inverse is taken as one.
        send_item(emc_pkg::OP_DECRYPT, '0, '0, '0, 31'd77);
        drain();
        // Operands above the modulus are reduced by the multiplications.
        write_all(31'd101, '1, 31'd55, '1);
        send_item(emc_pkg::OP_ENCRYPT, '1, 31'd99, '1, '1);
        send_item(emc_pkg::OP_DECRYPT, '1, '1, '1, '1);
        send_item(emc_pkg::OP_KEYGEN, '1, '1, '1, '1);
        drain();
        // Composite modulus: the inverse loop may stop on a zero remainder.
        write_all(31'd1000, 31'd6, 31'd3, 31'd8);
        send_item(emc_pkg::OP_DECRYPT, '0, '0, 31'd10, 31'd999);
        send_item(emc_pkg::OP_DECRYPT, '0, '0, 31'd3, 31'd7);
        send_item(emc_pkg::OP_ENCRYPT, 31'd500, 31'd17, '0, '0);
        send_item(emc_pkg::OP_UNUSED, '0, '0, '0, '0);
        send_item(emc_pkg::OP_KEYGEN, '0, '0, '0, '0);
        drain();
    endtask

    // The receiver holds off while items keep coming, so the unit fills and stalls
    // its input; then the sender pauses until everything is back.
    task automatic test_backpressure;
        int count;
        count = 0;
        write_all(31'd65521, 31'd17, rand_field(), rand_field());
        idle_style = IDLE_NONE;
        hold_left  = 30000;
        while (count < 4)
            send_random(count);
        drain();
    endtask

    // Receiver: random stalls by style, or a long hold-off counted down here.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (idle_style == IDLE_RECEIVER)
            m_tready <= ($urandom_range(0, 99) >= 83);
        else if (idle_style == IDLE_BOTH)
            m_tready <= ($urandom_range(0, 99) >= 33);
        else
            m_tready <= 1'b1;
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        cipher_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("done_kind", m_tuser, want.kind);
                if (m_tdata[30:0] !== want.prim)
                    report_mismatch("primary_value", m_tdata[30:0], want.prim);
                if (m_tdata[61:31] !== want.sec)
                    report_mismatch("secondary_value", m_tdata[61:31], want.sec);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        wr_en      = 1'b0;
        wr_index   = '0;
        wr_data    = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        idle_style = IDLE_NONE;
        hold_left  = 0;
        errors     = 0;
        cycles     = 0;
        q_mod      = 31'd2;
        gen_base   = '0;
        priv_exp   = '0;
        pub_val    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        random_phase(IDLE_NONE, 30);
        random_phase(IDLE_SENDER, 30);
        random_phase(IDLE_RECEIVER, 30);
        random_phase(IDLE_BOTH, 30);
        test_backpressure();

        drain();
        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/emc_pkg.sv
rtl/emc_modmul.sv
rtl/emc_divstep.sv
rtl/elgamal_modular_cipher_unit.sv
tb/tb.sv
